// ----- rtl/gtg_pkg.sv -----
package gtg_pkg;

  localparam int unsigned NumIter = 16;
  localparam int unsigned AtanLen = 24;
  localparam int unsigned Iw      = 48;
  localparam int unsigned Zw      = 28;

  localparam logic signed [Zw-1:0] PiQ24     = Zw'(52707179);
  localparam logic signed [Zw-1:0] HalfPiQ24 = Zw'(26353589);
  localparam logic [29:0]          InvKQ30   = 30'd652032874;

  localparam logic [10:0] TolReset  = 11'd20;
  localparam logic [11:0] KLinReset = 12'd512;
  localparam logic [11:0] KAngReset = 12'd512;

  typedef enum logic [1:0] {
    RegTol  = 2'd0,
    RegKLin = 2'd1,
    RegKAng = 2'd2
  } cfg_reg_e;

  typedef struct packed {
    logic               reached;
    logic               behind;
    logic               ty_neg;
    logic               zero_vec;
    logic signed [Iw-1:0] x;
    logic signed [Iw-1:0] y;
    logic signed [Zw-1:0] z;
    logic signed [Iw-1:0] tx;
  } gtg_stage_t;

  function automatic logic signed [Zw-1:0] atan_at(input int unsigned i);
    logic signed [Zw-1:0] v;
    begin
      case (i)
        0:  v = Zw'(13176795);
        1:  v = Zw'(7778716);
        2:  v = Zw'(4110060);
        3:  v = Zw'(2086331);
        4:  v = Zw'(1047214);
        5:  v = Zw'(524117);
        6:  v = Zw'(262123);
        7:  v = Zw'(131069);
        default: v = (i < AtanLen) ? (Zw'(65536) >>> (i - 8)) : '0;
      endcase
      return v;
    end
  endfunction

endpackage

// ----- rtl/gtg_cordic_stage.sv -----
module gtg_cordic_stage (
  input  logic                   clk_i,
  input  logic                   en_i,
  input  logic                   vec_mode_i,
  input  logic [4:0]             shift_i,
  input  logic signed [gtg_pkg::Zw-1:0] atan_i,
  input  gtg_pkg::gtg_stage_t    in_i,
  output gtg_pkg::gtg_stage_t    out_o
);
  import gtg_pkg::*;

  gtg_stage_t d;
  logic signed [Iw-1:0] xs, ys;
  logic dir_pos;

  always_comb begin
    d = in_i;
    xs = in_i.x >>> shift_i;
    ys = in_i.y >>> shift_i;
    // Rotation steers by the residual angle, vectoring by the sign of y.
    dir_pos = vec_mode_i ? in_i.y[Iw-1] : !in_i.z[Zw-1];
    if (dir_pos) begin
      d.x = in_i.x - ys;
      d.y = in_i.y + xs;
      d.z = vec_mode_i ? in_i.z - atan_i : in_i.z - atan_i;
    end else begin
      d.x = in_i.x + ys;
      d.y = in_i.y - xs;
      d.z = in_i.z + atan_i;
    end
    if (vec_mode_i && dir_pos) d.z = in_i.z - atan_i;
    if (vec_mode_i && !dir_pos) d.z = in_i.z + atan_i;
  end

  always_ff @(posedge clk_i) begin
    if (en_i) out_o <= d;
  end
endmodule

// ----- rtl/go_to_goal_p_controller.sv -----
// Channel  | Direction | Payload
// s_axis   | in        | tdata: pose_x, pose_y, pose_heading, target_x, target_y
// m_axis   | out       | tdata: forward_speed, turn_rate; tuser: reached
// cfg      | in        | cfg_idx_i register index, cfg_data_i value
// One word enters per cycle while the pipeline advances; the data path holds the
// two 16-stage CORDIC chains. All stages advance together when the output is free
// or empty. Reset clears the valid bits and loads the register defaults.
module go_to_goal_p_controller (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [79:0] s_axis_tdata,  // pose_x, pose_y, pose_heading, target_x, target_y
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [47:0] m_axis_tdata,  // forward_speed[23:0], turn_rate[43:24], zeros
  output logic        m_axis_tuser,  // reached
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [1:0]  cfg_idx_i,
  input  logic [11:0] cfg_data_i
);
  import gtg_pkg::*;

  localparam int unsigned Depth = 2 * NumIter + 6;

  logic [10:0] tol_q;
  logic [11:0] klin_q, kang_q;
  logic [Depth-1:0] vld_q;
  logic en;

  assign en = !vld_q[Depth-1] || m_axis_tready;
  assign s_axis_tready = en;
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tol_q <= TolReset; klin_q <= KLinReset; kang_q <= KAngReset;
    end else if (cfg_valid_i) begin
      unique case (cfg_idx_i)
        RegTol:  tol_q  <= cfg_data_i[10:0];
        RegKLin: klin_q <= cfg_data_i;
        RegKAng: kang_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) vld_q <= '0;
    else if (en) vld_q <= {vld_q[Depth-2:0], s_axis_tvalid};
  end

  // Stage 0: offsets.
  logic signed [16:0] dx_q, dy_q;
  logic signed [15:0] hd_q;
  always_ff @(posedge clk_i) begin
    if (en) begin
      dx_q <= 17'(signed'(s_axis_tdata[63:48])) - 17'(signed'(s_axis_tdata[15:0]));
      dy_q <= 17'(signed'(s_axis_tdata[79:64])) - 17'(signed'(s_axis_tdata[31:16]));
      hd_q <= s_axis_tdata[47:32];
    end
  end

  // Stage 1: squared distance and angle reduction.
  gtg_stage_t s1_q;
  gtg_stage_t s1_d;
  logic [34:0] dist2;
  logic [21:0] tol2;
  always_comb begin
    dist2 = 35'(dx_q * dx_q) + 35'(dy_q * dy_q);
    tol2  = 22'(tol_q) * 22'(tol_q);
    s1_d = '0;
    s1_d.reached = dist2 <= 35'(tol2);
    s1_d.x = Iw'(dx_q) <<< 12;
    s1_d.y = Iw'(dy_q) <<< 12;
    s1_d.z = -(Zw'(hd_q) <<< 11);
    if (s1_d.z > HalfPiQ24) begin
      s1_d.z = s1_d.z - PiQ24; s1_d.x = -s1_d.x; s1_d.y = -s1_d.y;
    end else if (s1_d.z < -HalfPiQ24) begin
      s1_d.z = s1_d.z + PiQ24; s1_d.x = -s1_d.x; s1_d.y = -s1_d.y;
    end
  end
  always_ff @(posedge clk_i) if (en) s1_q <= s1_d;

  // Rotation chain.
  gtg_stage_t rot [NumIter+1];
  assign rot[0] = s1_q;
  for (genvar i = 0; i < NumIter; i++) begin : g_rot
    gtg_cordic_stage u_st (
      .clk_i, .en_i(en), .vec_mode_i(1'b0), .shift_i(5'(i)),
      .atan_i(atan_at(i)), .in_i(rot[i]), .out_o(rot[i+1]));
  end

  // Gain compensation multiply (x*1/K). The rotated vector always fits in 32 bits.
  logic signed [31:0] rx, ry;
  logic signed [62:0] mx_q, my_q;
  gtg_stage_t sm_q;
  assign rx = rot[NumIter].x[31:0];
  assign ry = rot[NumIter].y[31:0];
  always_ff @(posedge clk_i) begin
    if (en) begin
      mx_q <= 63'(rx) * 63'($signed({1'b0, InvKQ30}));
      my_q <= 63'(ry) * 63'($signed({1'b0, InvKQ30}));
      sm_q <= rot[NumIter];
    end
  end

  // Quadrant fold for vectoring.
  gtg_stage_t v0_q, v0_d;
  logic signed [Iw-1:0] tx, ty;
  always_comb begin
    tx = Iw'(mx_q >>> 30);
    ty = Iw'(my_q >>> 30);
    v0_d = sm_q;
    v0_d.tx = tx;
    v0_d.behind = tx[Iw-1];
    v0_d.ty_neg = ty[Iw-1];
    v0_d.zero_vec = (klin_q == '0) || (tx == '0 && ty == '0);
    v0_d.x = tx[Iw-1] ? -tx : tx;
    v0_d.y = tx[Iw-1] ? -ty : ty;
    v0_d.z = '0;
  end
  always_ff @(posedge clk_i) if (en) v0_q <= v0_d;

  gtg_stage_t vec [NumIter+1];
  assign vec[0] = v0_q;
  for (genvar i = 0; i < NumIter; i++) begin : g_vec
    gtg_cordic_stage u_st (
      .clk_i, .en_i(en), .vec_mode_i(1'b1), .shift_i(5'(i)),
      .atan_i(atan_at(i)), .in_i(vec[i]), .out_o(vec[i+1]));
  end

  // Output products.
  logic signed [Zw-1:0] ang;
  logic signed [Iw+13:0] fwd_p_q;
  logic signed [Zw+13:0] turn_p_q;
  logic reached_q;
  gtg_stage_t ve;
  assign ve = vec[NumIter];
  always_comb begin
    if (ve.zero_vec) ang = '0;
    else if (ve.behind) ang = (ve.ty_neg ? -PiQ24 : PiQ24) + ve.z;
    else ang = ve.z;
  end
  always_ff @(posedge clk_i) begin
    if (en) begin
      fwd_p_q  <= (Iw+14)'(ve.tx) * (Iw+14)'($signed({1'b0, klin_q}));
      turn_p_q <= (Zw+14)'(ang) * (Zw+14)'($signed({1'b0, kang_q}));
      reached_q <= ve.reached;
    end
  end

  // Rounding and saturation.
  logic signed [Iw+13:0] fwd_r;
  logic signed [Zw+13:0] turn_r;
  logic [23:0] fwd_s_q;
  logic [19:0] turn_s_q;
  logic reached2_q;
  always_comb begin
    fwd_r  = (fwd_p_q + (Iw+14)'(1 << 19)) >>> 20;
    turn_r = (turn_p_q + (Zw+14)'(1 << 18)) >>> 19;
  end
  always_ff @(posedge clk_i) begin
    if (en) begin
      reached2_q <= reached_q;
      if (reached_q) begin
        fwd_s_q <= '0; turn_s_q <= '0;
      end else begin
        if (fwd_r > (Iw+14)'(8388607)) fwd_s_q <= 24'h7FFFFF;
        else if (fwd_r < -(Iw+14)'(8388608)) fwd_s_q <= 24'h800000;
        else fwd_s_q <= fwd_r[23:0];
        if (turn_r > (Zw+14)'(524287)) turn_s_q <= 20'h7FFFF;
        else if (turn_r < -(Zw+14)'(524288)) turn_s_q <= 20'h80000;
        else turn_s_q <= turn_r[19:0];
      end
    end
  end

  assign m_axis_tvalid = vld_q[Depth-1];
  assign m_axis_tdata  = {4'b0, turn_s_q, fwd_s_q};
  assign m_axis_tuser  = reached2_q;
endmodule

// ----- rtl/gtg_checker.sv -----
module gtg_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        s_axis_tready,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [47:0] m_axis_tdata,
  input logic        m_axis_tuser
);
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("output word dropped during stall");
  a_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser |-> m_axis_tdata == '0)
    else $error("reached with nonzero speed");
  a_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |-> !s_axis_tready)
    else $error("pipeline advanced under stall");
endmodule

bind go_to_goal_p_controller gtg_checker u_chk (.*);
